// ===== rtl/core/autorange_capacitance_meter_defines.svh =====
// assertion macros for the capacitance meter checker
`ifndef AUTORANGE_CAPACITANCE_METER_DEFINES_SVH
`define AUTORANGE_CAPACITANCE_METER_DEFINES_SVH
// assert that a condition implies a consequence on the same edge
`define ACM_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// assert that a condition implies a consequence on the next edge
`define ACM_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ===== rtl/core/acm_pkg.sv =====
// shared types and constants of the capacitance meter
package acm_pkg;
	localparam int COUNT_WIDTH_DEF   = 16;
	localparam int FRACTION_BITS_DEF = 8;

	localparam logic [2:0] REG_WIN_LOW  = 3'd0;
	localparam logic [2:0] REG_WIN_HIGH = 3'd1;
	localparam logic [2:0] REG_CALI_MV  = 3'd2;
	localparam logic [2:0] REG_MEAS_MV  = 3'd3;
	localparam logic [2:0] REG_CALI_REF = 3'd4;
	localparam logic [2:0] REG_WAIT_LIM = 3'd5;
	localparam logic [2:0] REG_DIS_STEP = 3'd6;

	localparam logic [1:0] RANGE_UF = 2'd0;
	localparam logic [1:0] RANGE_NF = 2'd1;
	localparam logic [1:0] RANGE_PF = 2'd2;

	localparam logic [1:0] ST_NONE    = 2'd0;
	localparam logic [1:0] ST_RERANGE = 2'd1;
	localparam logic [1:0] ST_OVER    = 2'd2;
	localparam logic [1:0] ST_NORMAL  = 2'd3;

	localparam logic [3:0] PH_START    = 4'd1;
	localparam logic [3:0] PH_CAL_DIS  = 4'd2;
	localparam logic [3:0] PH_CAL_CHG  = 4'd3;
	localparam logic [3:0] PH_CAL_WAIT = 4'd4;
	localparam logic [3:0] PH_IDLE     = 4'd5;
	localparam logic [3:0] PH_DIS      = 4'd6;
	localparam logic [3:0] PH_CHG      = 4'd7;
	localparam logic [3:0] PH_WAIT     = 4'd8;
	localparam logic [3:0] PH_CALC     = 4'd9;

	typedef enum logic [1:0] {
		CTL_IDLE,
		CTL_MUL,
		CTL_DIV,
		CTL_OUT
	} ctl_state_t;

	typedef struct packed {
		logic start;
		logic busy;
		logic done;
	} div_ctl_t;
endpackage

// ===== rtl/core/acm_divider.sv =====
// shift-add multiplier and restoring divider for the capacitance value
module acm_divider #(
	parameter int COUNT_WIDTH   = acm_pkg::COUNT_WIDTH_DEF,
	parameter int FRACTION_BITS = acm_pkg::FRACTION_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [COUNT_WIDTH-1:0] count,
	input  logic [15:0]            cref,
	input  logic [COUNT_WIDTH-1:0] cal,
	input  logic                   uf,
	output logic                   busy,
	output logic                   done,
	output logic [31:0]            quot
);
	import acm_pkg::*;

	localparam int PW  = COUNT_WIDTH + 16;
	localparam int NW  = PW + FRACTION_BITS;
	localparam int DW  = COUNT_WIDTH + 4;
	localparam int CW  = $clog2(NW + 1);
	localparam int MCW = $clog2(PW + 1);

	ctl_state_t        st_q;
	logic [NW-1:0]     num_q;
	logic [DW-1:0]     den_q;
	logic [DW:0]       rem_q;
	logic [CW-1:0]     cnt_q;
	logic [15:0]       mb_q;
	logic [PW-1:0]     ma_q;
	logic [MCW-1:0]    mcnt_q;
	logic              sat_q;
	logic [DW:0]       trial;
	logic [DW:0]       diff;

	assign trial = {rem_q[DW-1:0], num_q[NW-1]};
	assign diff  = trial - {1'b0, den_q};
	assign busy  = (st_q != CTL_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= CTL_IDLE;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (st_q)
				CTL_IDLE: if (start) st_q <= CTL_MUL;
				CTL_MUL: if (mcnt_q == MCW'(16)) st_q <= CTL_DIV;
				CTL_DIV: if (sat_q || cnt_q == CW'(NW)) st_q <= CTL_OUT;
				CTL_OUT: begin
					st_q <= CTL_IDLE;
					done <= 1'b1;
				end
				default: st_q <= CTL_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			CTL_IDLE: begin
				num_q  <= '0;
				ma_q   <= PW'(count);
				mb_q   <= cref;
				mcnt_q <= '0;
				cnt_q  <= '0;
				rem_q  <= '0;
				den_q  <= uf ? (DW'(cal) << 3) + (DW'(cal) << 1) : DW'(cal);
				sat_q  <= (cal == '0);
			end
			CTL_MUL: begin
				// product builds in the numerator, fraction bits stay zero
				if (mb_q[0]) num_q <= num_q + (NW'(ma_q) << FRACTION_BITS);
				ma_q   <= ma_q << 1;
				mb_q   <= mb_q >> 1;
				mcnt_q <= mcnt_q + 1'b1;
			end
			CTL_DIV: begin
				if (!sat_q && cnt_q != CW'(NW)) begin
					if (!diff[DW]) begin
						rem_q <= diff;
						num_q <= {num_q[NW-2:0], 1'b1};
					end else begin
						rem_q <= trial;
						num_q <= {num_q[NW-2:0], 1'b0};
					end
					cnt_q <= cnt_q + 1'b1;
				end
			end
			CTL_OUT: begin
				if (sat_q) quot <= '1;
				else if (NW > 32 && |(num_q >> 32)) quot <= '1;
				else quot <= 32'(num_q);
			end
			default: ;
		endcase
	end
endmodule

// ===== rtl/core/autorange_capacitance_meter.sv =====
// top level of the auto-ranging charge-time capacitance meter
//  channel  valid     stall     payload
//  in       in_valid  in_stall  action adc_mv own_request other_busy
//  out      out_valid out_stall range_switches .. value_ready
//  cfg      cfg_we    -         cfg_index cfg_data
// ticks and ordinary steps: the beat is registered in pend_q, then in out_valid; no input is accepted until it leaves
// the capacitance step runs the divider: a shift-add multiply, then a restoring divide
// in_stall stays high while a beat is built or waits, or the divider runs
// reset puts the sequencer before its start phase with the meter discharged
module autorange_capacitance_meter #(
	parameter int COUNT_WIDTH   = acm_pkg::COUNT_WIDTH_DEF,
	parameter int FRACTION_BITS = acm_pkg::FRACTION_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        action,
	input  logic [12:0] adc_mv,
	input  logic        own_request,
	input  logic        other_busy,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  range_switches,
	output logic        charging,
	output logic        measure_mode,
	output logic [6:0]  progress,
	output logic [1:0]  result_status,
	output logic [1:0]  active_range,
	output logic [31:0] cap_value,
	output logic        value_ready
);
	import acm_pkg::*;

	logic [12:0] win_lo_q, win_hi_q, cali_mv_q, meas_mv_q;
	logic [15:0] cref_q;
	logic [7:0]  wait_lim_q, dis_steps_q;

	logic [3:0]             phase_q;
	logic [1:0]             nrange_q, crange_q;
	logic [COUNT_WIDTH-1:0] tick_q, cal_q;
	logic [7:0]             dwait_q, cwait_q;
	logic                   timer_q;
	logic [2:0]             sw_q;
	logic                   chg_q, mode_q;
	logic [6:0]             prog_q;
	logic [1:0]             stat_q;
	logic [31:0]            cap_q;
	logic                   pend_q;
	logic                   calc_q;
	div_ctl_t               dctl;
	logic [31:0]            quot;
	logic                   in_acc;
	logic [7:0]             dw_n, cw_n;

	assign in_stall = out_valid || pend_q || calc_q || dctl.busy;
	assign in_acc   = in_valid && !in_stall;
	assign dw_n     = dwait_q + 8'd1;
	assign cw_n     = cwait_q + 8'd1;
	assign dctl.start = in_acc && action && own_request && !other_busy &&
		phase_q == PH_CALC && crange_q <= RANGE_PF;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_lo_q <= 13'd2; win_hi_q <= 13'd1580;
			cali_mv_q <= 13'd1800; meas_mv_q <= 13'd2200;
			cref_q <= 16'd220; wait_lim_q <= 8'd55; dis_steps_q <= 8'd3;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WIN_LOW:  win_lo_q    <= cfg_data[12:0];
				REG_WIN_HIGH: win_hi_q    <= cfg_data[12:0];
				REG_CALI_MV:  cali_mv_q   <= cfg_data[12:0];
				REG_MEAS_MV:  meas_mv_q   <= cfg_data[12:0];
				REG_CALI_REF: cref_q      <= cfg_data;
				REG_WAIT_LIM: wait_lim_q  <= cfg_data[7:0];
				REG_DIS_STEP: dis_steps_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	acm_divider #(.COUNT_WIDTH(COUNT_WIDTH), .FRACTION_BITS(FRACTION_BITS)) u_div (
		.clk(clk), .arst_n(arst_n), .start(dctl.start), .count(tick_q),
		.cref(cref_q), .cal(cal_q), .uf(crange_q == RANGE_UF),
		.busy(dctl.busy), .done(dctl.done), .quot(quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0; nrange_q <= RANGE_UF; crange_q <= RANGE_UF;
			tick_q <= '0; cal_q <= '0; dwait_q <= '0; cwait_q <= '0;
			timer_q <= 1'b0; sw_q <= 3'b111; chg_q <= 1'b0; mode_q <= 1'b0;
			prog_q <= '0; stat_q <= ST_NONE; cap_q <= '0;
			pend_q <= 1'b0; calc_q <= 1'b0; out_valid <= 1'b0; value_ready <= 1'b0;
		end else begin
			if (out_valid && !out_stall) out_valid <= 1'b0;
			if (pend_q) begin
				// register the beat from the updated state
				pend_q <= 1'b0; out_valid <= 1'b1;
			end
			if (dctl.done) begin
				cap_q <= quot; calc_q <= 1'b0; out_valid <= 1'b1;
			end
			if (in_acc) begin
				value_ready <= action && own_request && !other_busy && phase_q == PH_CALC;
				pend_q <= !dctl.start;
				if (!action) begin
					if (timer_q && adc_mv > win_lo_q && adc_mv < win_hi_q)
						tick_q <= tick_q + 1'b1;
				end else if (own_request && !other_busy) begin
					case (phase_q)
						PH_START: begin
							prog_q <= 7'd1; mode_q <= 1'b0; phase_q <= PH_CAL_DIS;
							sw_q <= 3'b111; chg_q <= 1'b0;
						end
						PH_CAL_DIS, PH_DIS: begin
							if (dw_n > dis_steps_q) begin
								dwait_q <= '0;
								prog_q  <= (phase_q == PH_CAL_DIS) ? 7'd10 : 7'd50;
								phase_q <= (phase_q == PH_CAL_DIS) ? PH_CAL_CHG : PH_CHG;
							end else
								dwait_q <= dw_n;
						end
						PH_CAL_CHG: begin
							chg_q <= 1'b1; sw_q <= 3'b110; crange_q <= RANGE_UF;
							timer_q <= 1'b1; phase_q <= PH_CAL_WAIT; prog_q <= 7'd15;
						end
						PH_CAL_WAIT: begin
							if (adc_mv > cali_mv_q) begin
								cal_q <= tick_q; tick_q <= '0; timer_q <= 1'b0;
								phase_q <= PH_DIS; sw_q <= 3'b111; chg_q <= 1'b0;
								mode_q <= 1'b1; prog_q <= 7'd20;
							end
						end
						PH_IDLE: ;
						PH_CHG: begin
							tick_q <= '0; chg_q <= 1'b1;
							if (nrange_q <= RANGE_PF) begin
								sw_q <= 3'b111 & ~(3'b001 << nrange_q);
								crange_q <= nrange_q;
							end
							timer_q <= 1'b1; phase_q <= PH_WAIT; prog_q <= 7'd70;
						end
						PH_WAIT: begin
							if (cw_n > wait_lim_q || adc_mv > meas_mv_q) begin
								cwait_q <= '0; timer_q <= 1'b0; prog_q <= 7'd90;
								if (nrange_q <= RANGE_PF) begin
									sw_q <= 3'b111; chg_q <= 1'b0; mode_q <= 1'b1;
								end
								case (nrange_q)
									RANGE_UF: begin
										if (32'(tick_q) < 32'd40) begin
											nrange_q <= RANGE_NF; stat_q <= ST_RERANGE;
											phase_q <= PH_DIS;
										end else if (32'(tick_q) > 32'd3200) begin
											stat_q <= ST_OVER; phase_q <= PH_DIS;
										end else begin
											stat_q <= ST_NORMAL; phase_q <= PH_CALC;
										end
									end
									RANGE_NF: begin
										if (32'(tick_q) < 32'd4) begin
											nrange_q <= RANGE_PF; stat_q <= ST_RERANGE;
											phase_q <= PH_DIS;
										end else if (32'(tick_q) > 32'd4000) begin
											nrange_q <= RANGE_UF; stat_q <= ST_RERANGE;
											phase_q <= PH_DIS;
										end else begin
											stat_q <= ST_NORMAL; phase_q <= PH_CALC;
										end
									end
									RANGE_PF: begin
										if (32'(tick_q) < 32'd4) begin
											stat_q <= ST_OVER; phase_q <= PH_DIS;
										end else if (32'(tick_q) > 32'd4000) begin
											nrange_q <= RANGE_NF; stat_q <= ST_RERANGE;
											phase_q <= PH_DIS;
										end else begin
											stat_q <= ST_NORMAL; phase_q <= PH_CALC;
										end
									end
									// unused range code leaves range and status alone
									default: ;
								endcase
							end else
								cwait_q <= cw_n;
						end
						PH_CALC: begin
							prog_q <= 7'd100; phase_q <= PH_DIS;
							if (crange_q <= RANGE_PF)
								calc_q <= 1'b1;
						end
						default: phase_q <= PH_START;
					endcase
				end
			end
		end
	end

	assign range_switches = sw_q;
	assign charging       = chg_q;
	assign measure_mode   = mode_q;
	assign progress       = prog_q;
	assign result_status  = stat_q;
	assign active_range   = crange_q;
	assign cap_value      = cap_q;
endmodule

// ===== rtl/core/acm_checker.sv =====
// port-level checker for the capacitance meter, bound to the top level
`include "autorange_capacitance_meter_defines.svh"
module acm_props (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [2:0]  range_switches,
	input logic        charging,
	input logic [6:0]  progress,
	input logic        value_ready
);
	`ACM_ASSERT_IMP(a_one_switch, charging, $countones(range_switches) == 2,
		"charging without exactly one range selected")
	`ACM_ASSERT_IMP(a_ready_full, out_valid && value_ready, progress == 7'd100,
		"value beat without full progress")
	`ACM_ASSERT_IMP(a_stall_out, out_valid, in_stall,
		"input open while a beat waits")
	`ACM_ASSERT_NXT(a_hold, out_valid && out_stall, out_valid && $stable(progress),
		"stalled beat changed")
endmodule

bind autorange_capacitance_meter acm_props u_acm_props (
	.clk(clk), .arst_n(arst_n), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .range_switches(range_switches),
	.charging(charging), .progress(progress), .value_ready(value_ready)
);
